// ===== rtl/core/tcoe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcoe_pkg - shared types and constants of the clock offset estimator
// Holds the request and result layouts, the configuration set, the queue
// entry between front and back, and the fixed timing constants.
// ----------------------------------------------------------------------------
package tcoe_pkg;

	// Pipeline depth of the front part and the output queue depth.
	localparam int FRONT_STAGES = 6;
	localparam int INFLIGHT_W   = $clog2(FRONT_STAGES + 1);
	localparam int OUT_DEPTH    = 2;

	// Configuration port geometry and register indexes.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] REG_OPTION_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MSGS_NEEDED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_MS    = 2'd2;

	// Time constants in milliseconds.
	localparam logic [26:0] DAY_MS   = 27'd86400000;
	localparam logic [26:0] HALF_DAY = 27'd43200000;
	localparam logic [26:0] RTT_CAP  = 27'd86399999;

	// Magnitude / DAY_MS is estimated as (mag >> RECIP_LO) * DAY_RECIP >> RECIP_SHIFT.
	// The estimate never exceeds the true quotient and is at most one below it.
	localparam int RECIP_LO    = 17;
	localparam int RECIP_SHIFT = 20;
	localparam logic [10:0] DAY_RECIP = 11'd1590;

	// Reset values.
	localparam logic signed [31:0] NOT_SET = 32'sh7FFFFFFF;
	localparam logic [26:0] RTT_RESET    = 27'd1000;
	localparam logic [7:0]  TARGET_RESET = 8'd50;
	localparam logic [9:0]  RANGE_RESET  = 10'd1;
	localparam logic [7:0]  COUNT_MAX    = 8'hFF;

	// Request classes found by the front part.
	localparam logic [2:0] KIND_START   = 3'd0;
	localparam logic [2:0] KIND_REPLY   = 3'd1;
	localparam logic [2:0] KIND_SKIP    = 3'd2;
	localparam logic [2:0] KIND_NONSTD  = 3'd3;
	localparam logic [2:0] KIND_MISSING = 3'd4;

	// Result status codes.
	localparam logic [2:0] ST_ACCEPTED = 3'd0;
	localparam logic [2:0] ST_IN_RANGE = 3'd1;
	localparam logic [2:0] ST_SKIPPED  = 3'd2;
	localparam logic [2:0] ST_NONSTD   = 3'd3;
	localparam logic [2:0] ST_MISSING  = 3'd4;

	typedef struct packed {
		logic        command;
		logic [31:0] send_ms;
		logic [31:0] peer1_ms;
		logic [31:0] peer2_ms;
		logic [31:0] recv_ms;
	} sample_t;

	typedef struct packed {
		logic [2:0]         status;
		logic               done_res;
		logic [26:0]        rtt_ms;
		logic [26:0]        sigma_ms;
		logic signed [31:0] min_rtt_ms;
		logic signed [31:0] path_offset_ms;
		logic signed [31:0] offset_ms;
		logic [7:0]         accepted_count;
	} result_t;

	typedef struct packed {
		logic       option_mode;
		logic [7:0] msgs_needed;
		logic [9:0] range_ms;
	} cfg_t;

	// Classified request handed from the front part to the back part.
	typedef struct packed {
		logic [2:0]         kind;
		logic               plain_nonstd;
		logic               in_range;
		logic [26:0]        dcl;
		logic signed [26:0] fwd;
		logic signed [26:0] bwd;
		logic signed [27:0] sum;
		logic signed [26:0] half;
	} mid_item_t;

endpackage
`default_nettype wire

// ===== rtl/core/tcoe_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcoe_fifo - small synchronous queue
// Register-based first-in first-out queue with a fill count. DEPTH is a
// power of two of at least two; the head entry is always on rd_data.
// ----------------------------------------------------------------------------
module tcoe_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty,
	output logic [CNT_W-1:0] count
);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data = store_q[rd_ptr_q];
	assign empty   = (count_q == '0);
	assign count   = count_q;

endmodule
`default_nettype wire

// ===== rtl/core/tcoe_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcoe_front - request classification and day folding
// Six-stage pipeline that classifies each request, clamps the round trip,
// and folds the forward and backward deltas into plus or minus half a day.
// It never stalls; the top level grants requests only with queue room.
// ----------------------------------------------------------------------------
module tcoe_front
	import tcoe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  sample_t               in_item,
	input  cfg_t                  cfg,
	output logic                  out_valid,
	output mid_item_t             out_item,
	output logic [INFLIGHT_W-1:0] inflight
);

	localparam int LANES    = 2;
	localparam int LANE_FWD = 0;
	localparam int LANE_BWD = 1;

	typedef struct packed {
		logic [2:0]  kind;
		logic        plain_nonstd;
		logic        in_range;
		logic [26:0] dcl;
	} info_t;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	// Stage 1 signals.
	logic              any_top;
	logic              any_zero;
	logic [31:0]       back_ref;
	logic              cmd_s1;
	logic              opt_nonstd_s1;
	logic              opt_missing_s1;
	logic              plain_nonstd_s1;
	logic [32:0]       diff_s1;
	logic [LANES-1:0][32:0] dlt_s1;

	// Stage 2 signals.
	info_t                  info_c2;
	logic [LANES-1:0][32:0] neg_c2;
	logic [LANES-1:0][31:0] mag_c2;
	info_t                  info_s2;
	logic [LANES-1:0][31:0] mag_s2;
	logic [LANES-1:0]       sgn_s2;

	// Stage 3 signals.
	logic [LANES-1:0][25:0] prod_c3;
	info_t                  info_s3;
	logic [LANES-1:0][31:0] mag_s3;
	logic [LANES-1:0]       sgn_s3;
	logic [LANES-1:0][5:0]  est_s3;

	// Stage 4 signals.
	logic [LANES-1:0][31:0] rem_c4;
	info_t                  info_s4;
	logic [LANES-1:0]       sgn_s4;
	logic [LANES-1:0][27:0] r0_s4;

	// Stage 5 signals.
	logic [LANES-1:0][27:0] red_c5;
	logic [LANES-1:0][26:0] mod_c5;
	logic [LANES-1:0][26:0] fold_c5;
	info_t                  info_s5;
	logic [LANES-1:0][26:0] fold_s5;

	// Stage 6 signals.
	logic [27:0] fwd_x;
	logic [27:0] bwd_x;
	logic [27:0] dd_c6;
	logic [27:0] hsum_c6;
	mid_item_t   item_c6;
	mid_item_t   item_s6;

	// Valid bits of all stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// Stage 1: format checks and raw differences.
	assign any_top  = in_item.send_ms[31] | in_item.peer1_ms[31] |
			in_item.peer2_ms[31] | in_item.recv_ms[31];
	assign any_zero = (in_item.send_ms == '0) || (in_item.peer1_ms == '0) ||
			(in_item.peer2_ms == '0) || (in_item.recv_ms == '0);
	assign back_ref = cfg.option_mode ? in_item.peer2_ms : in_item.peer1_ms;

	always_ff @(posedge clk) begin
		cmd_s1           <= in_item.command;
		opt_nonstd_s1    <= cfg.option_mode & any_top;
		opt_missing_s1   <= cfg.option_mode & any_zero;
		plain_nonstd_s1  <= ~cfg.option_mode & in_item.peer1_ms[31];
		diff_s1          <= {1'b0, in_item.recv_ms} - {1'b0, in_item.send_ms};
		dlt_s1[LANE_FWD] <= {1'b0, in_item.peer1_ms} - {1'b0, in_item.send_ms};
		dlt_s1[LANE_BWD] <= {1'b0, in_item.recv_ms} - {1'b0, back_ref};
	end

	// Stage 2: class, clamped round trip, range test and delta magnitudes.
	always_comb begin
		info_c2.plain_nonstd = plain_nonstd_s1;
		priority if (!cmd_s1) begin
			info_c2.kind = KIND_START;
		end else if (opt_nonstd_s1) begin
			info_c2.kind = KIND_NONSTD;
		end else if (opt_missing_s1) begin
			info_c2.kind = KIND_MISSING;
		end else if (diff_s1[32]) begin
			info_c2.kind = KIND_SKIP;
		end else begin
			info_c2.kind = KIND_REPLY;
		end
		info_c2.dcl = (diff_s1[31:0] > {5'd0, RTT_CAP}) ? RTT_CAP : diff_s1[26:0];
		info_c2.in_range = (diff_s1[31:0] < {22'd0, cfg.range_ms});
		for (int j = 0; j < LANES; j++) begin
			neg_c2[j] = 33'd0 - dlt_s1[j];
			mag_c2[j] = dlt_s1[j][32] ? neg_c2[j][31:0] : dlt_s1[j][31:0];
		end
	end

	always_ff @(posedge clk) begin
		info_s2 <= info_c2;
		mag_s2  <= mag_c2;
		for (int j = 0; j < LANES; j++) begin
			sgn_s2[j] <= dlt_s1[j][32];
		end
	end

	// Stage 3: whole days estimated by a reciprocal multiply.
	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			prod_c3[j] = {11'd0, mag_s2[j][31:RECIP_LO]} * {15'd0, DAY_RECIP};
		end
	end

	always_ff @(posedge clk) begin
		info_s3 <= info_s2;
		mag_s3  <= mag_s2;
		sgn_s3  <= sgn_s2;
		for (int j = 0; j < LANES; j++) begin
			est_s3[j] <= prod_c3[j][25:RECIP_SHIFT];
		end
	end

	// Stage 4: remainder after the estimated days, below two days.
	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			rem_c4[j] = mag_s3[j] - (32'(est_s3[j]) * 32'(DAY_MS));
		end
	end

	always_ff @(posedge clk) begin
		info_s4 <= info_s3;
		sgn_s4  <= sgn_s3;
		for (int j = 0; j < LANES; j++) begin
			r0_s4[j] <= rem_c4[j][27:0];
		end
	end

	// Stage 5: final correction and fold into the signed half-day range.
	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			red_c5[j] = r0_s4[j] - {1'b0, DAY_MS};
			mod_c5[j] = (r0_s4[j] >= {1'b0, DAY_MS}) ? red_c5[j][26:0] : r0_s4[j][26:0];
			if (!sgn_s4[j]) begin
				fold_c5[j] = (mod_c5[j] >= HALF_DAY) ? mod_c5[j] - DAY_MS : mod_c5[j];
			end else begin
				fold_c5[j] = (mod_c5[j] <= HALF_DAY) ? 27'd0 - mod_c5[j] : DAY_MS - mod_c5[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		info_s5 <= info_s4;
		fold_s5 <= fold_c5;
	end

	// Stage 6: delta sum and the halved difference, truncated toward zero.
	always_comb begin
		fwd_x   = {fold_s5[LANE_FWD][26], fold_s5[LANE_FWD]};
		bwd_x   = {fold_s5[LANE_BWD][26], fold_s5[LANE_BWD]};
		dd_c6   = fwd_x - bwd_x;
		hsum_c6 = dd_c6 + {27'd0, dd_c6[27]};
		item_c6.kind         = info_s5.kind;
		item_c6.plain_nonstd = info_s5.plain_nonstd;
		item_c6.in_range     = info_s5.in_range;
		item_c6.dcl          = info_s5.dcl;
		item_c6.fwd          = fold_s5[LANE_FWD];
		item_c6.bwd          = fold_s5[LANE_BWD];
		item_c6.sum          = fwd_x + bwd_x;
		item_c6.half         = hsum_c6[27:1];
	end

	always_ff @(posedge clk) begin
		item_s6 <= item_c6;
	end

	assign out_valid = vld_s6;
	assign out_item  = item_s6;
	assign inflight  = INFLIGHT_W'($countones({vld_s1, vld_s2, vld_s3,
			vld_s4, vld_s5, vld_s6}));

endmodule
`default_nettype wire

// ===== rtl/core/tcoe_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcoe_back - measurement state update
// Takes one classified request per cycle from the queue while the output
// queue has room, updates the running averages, direction minima, least
// delta sum and offsets, and produces the matching result.
// ----------------------------------------------------------------------------
module tcoe_back
	import tcoe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      item_valid,
	input  mid_item_t item,
	input  logic      res_space,
	output logic      item_pop,
	output logic      res_valid,
	output result_t   res
);

	logic               active_q;
	logic [26:0]        rtt_q;
	logic [26:0]        dev_q;
	logic signed [31:0] min_fwd_q;
	logic signed [31:0] min_bwd_q;
	logic signed [31:0] least_q;
	logic signed [31:0] path_q;
	logic signed [31:0] final_q;
	logic [7:0]         count_q;

	logic               take;
	logic               active_n;
	logic [26:0]        rtt_n;
	logic [26:0]        dev_n;
	logic signed [31:0] min_fwd_n;
	logic signed [31:0] min_bwd_n;
	logic signed [31:0] least_n;
	logic signed [31:0] path_n;
	logic signed [31:0] final_n;
	logic [7:0]         count_n;
	logic [2:0]         status;

	logic [28:0]        rtt_sum;
	logic [26:0]        rtt_new;
	logic [27:0]        dev_diff;
	logic [27:0]        dev_neg;
	logic [26:0]        dev_abs;
	logic [28:0]        dev_sum;
	logic [7:0]         cnt_new;
	logic signed [31:0] fwd_x;
	logic signed [31:0] bwd_x;
	logic signed [31:0] sum_x;
	logic signed [31:0] half_x;
	logic signed [31:0] mf;
	logic signed [31:0] mb;
	logic [32:0]        fin_diff;
	logic [32:0]        fin_hsum;

	assign take      = item_valid & res_space;
	assign item_pop  = take;
	assign res_valid = take;

	// Next state for the request at the head of the queue.
	always_comb begin
		active_n  = active_q;
		rtt_n     = rtt_q;
		dev_n     = dev_q;
		min_fwd_n = min_fwd_q;
		min_bwd_n = min_bwd_q;
		least_n   = least_q;
		path_n    = path_q;
		final_n   = final_q;
		count_n   = count_q;
		status    = ST_SKIPPED;

		// Running averages as (3 * old + new) / 4.
		rtt_sum  = {2'b0, rtt_q} + {1'b0, rtt_q, 1'b0} + {2'b0, item.dcl};
		rtt_new  = rtt_sum[28:2];
		dev_diff = {1'b0, item.dcl} - {1'b0, rtt_new};
		dev_neg  = 28'd0 - dev_diff;
		dev_abs  = dev_diff[27] ? dev_neg[26:0] : dev_diff[26:0];
		dev_sum  = {2'b0, dev_q} + {1'b0, dev_q, 1'b0} + {2'b0, dev_abs};
		cnt_new  = (count_q == COUNT_MAX) ? count_q : count_q + 8'd1;

		// Direction minima, with a short round trip overriding both.
		fwd_x  = {{5{item.fwd[26]}}, item.fwd};
		bwd_x  = {{5{item.bwd[26]}}, item.bwd};
		sum_x  = {{4{item.sum[27]}}, item.sum};
		half_x = {{5{item.half[26]}}, item.half};
		mf = (fwd_x < min_fwd_q) ? fwd_x : min_fwd_q;
		mb = (bwd_x < min_bwd_q) ? bwd_x : min_bwd_q;
		if (item.in_range) begin
			mf = fwd_x;
			mb = bwd_x;
		end
		fin_diff = {mf[31], mf} - {mb[31], mb};
		fin_hsum = fin_diff + {32'd0, fin_diff[32]};

		if (item.kind == KIND_START) begin
			min_fwd_n = NOT_SET;
			min_bwd_n = NOT_SET;
			least_n   = NOT_SET;
			path_n    = NOT_SET;
			final_n   = NOT_SET;
			count_n   = 8'd0;
			active_n  = 1'b1;
			status    = ST_ACCEPTED;
		end else if (active_q) begin
			unique case (item.kind)
				KIND_NONSTD: begin
					active_n = 1'b0;
					status   = ST_NONSTD;
				end
				KIND_MISSING: begin
					active_n = 1'b0;
					status   = ST_MISSING;
				end
				KIND_REPLY: begin
					rtt_n   = rtt_new;
					dev_n   = dev_sum[28:2];
					count_n = cnt_new;
					if (item.plain_nonstd) begin
						active_n = 1'b0;
						status   = ST_NONSTD;
					end else begin
						min_fwd_n = mf;
						min_bwd_n = mb;
						if (sum_x < least_q) begin
							least_n = sum_x;
							path_n  = half_x;
						end
						status = item.in_range ? ST_IN_RANGE : ST_ACCEPTED;
						if (cnt_new >= cfg.msgs_needed) begin
							final_n  = fin_hsum[32:1];
							active_n = 1'b0;
						end
					end
				end
				default: begin
					status = ST_SKIPPED;
				end
			endcase
		end
	end

	// Result reports the state after the request.
	always_comb begin
		res.status         = status;
		res.done_res       = (final_n != NOT_SET);
		res.rtt_ms         = rtt_n;
		res.sigma_ms       = dev_n;
		res.min_rtt_ms     = least_n;
		res.path_offset_ms = path_n;
		res.offset_ms      = final_n;
		res.accepted_count = count_n;
	end

	// Measurement state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			rtt_q     <= RTT_RESET;
			dev_q     <= '0;
			min_fwd_q <= NOT_SET;
			min_bwd_q <= NOT_SET;
			least_q   <= NOT_SET;
			path_q    <= NOT_SET;
			final_q   <= NOT_SET;
			count_q   <= '0;
		end else if (take) begin
			active_q  <= active_n;
			rtt_q     <= rtt_n;
			dev_q     <= dev_n;
			min_fwd_q <= min_fwd_n;
			min_bwd_q <= min_bwd_n;
			least_q   <= least_n;
			path_q    <= path_n;
			final_q   <= final_n;
			count_q   <= count_n;
		end
	end

	// An open measurement never carries a final offset.
	a_active_no_final: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> final_q == NOT_SET)
		else $error("final offset present while a measurement is open");

	// A start request opens a clean measurement.
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && item.kind == KIND_START |=>
		active_q && count_q == 8'd0 && least_q == NOT_SET && final_q == NOT_SET)
		else $error("start request did not clear the measurement");

	// The averages stay within one day.
	a_avg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rtt_q <= RTT_CAP && dev_q <= RTT_CAP)
		else $error("running average beyond one day");

	// Only a start request lowers the reply count.
	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		take && item.kind != KIND_START |=> count_q >= $past(count_q))
		else $error("reply count decreased without a start request");

endmodule
`default_nettype wire

// ===== rtl/core/timestamp_clock_offset_estimator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// timestamp_clock_offset_estimator - clock offset from four-timestamp replies
// Estimates the offset of a peer clock from round trips carrying send,
// peer receive, peer transmit and local receive times of day.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while full is low and gives one
// result for each, in order. A request passes the front pipeline that
// classifies it and folds the forward and backward deltas into plus or minus
// twelve hours, then a queue of MID_DEPTH entries, then the back part, which
// updates the measurement state and writes the result into a two-entry output
// queue. The state update loop in the back part sets the sustained rate of one
// request per cycle, which holds with MID_DEPTH of eight or more while results
// are popped as they appear. There is no clearing pass after reset.
// Configuration is taken at any time through the configuration channel and
// must only change while the block is idle. A start request (command 0) opens
// a measurement; reply requests (command 1) then refine it until msgs_needed
// replies have been accepted.
// ----------------------------------------------------------------------------
module timestamp_clock_offset_estimator
	import tcoe_pkg::*;
#(
	parameter int MID_DEPTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  sample_t               sample,
	output logic                  empty,
	input  logic                  pop,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
	localparam int TOT_W     = $clog2(MID_DEPTH + FRONT_STAGES + 1);

	cfg_t                  cfg_q;
	logic                  in_take;
	logic                  front_valid;
	mid_item_t             front_item;
	logic [INFLIGHT_W-1:0] inflight;
	logic                  mid_empty;
	logic [MID_CNT_W-1:0]  mid_count;
	mid_item_t             mid_head;
	logic                  mid_pop;
	logic [TOT_W-1:0]      occupancy;
	logic                  res_valid;
	result_t               res;
	logic                  res_space;
	logic [OUT_CNT_W-1:0]  out_count;
	logic                  out_pop;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.option_mode <= 1'b0;
			cfg_q.msgs_needed <= TARGET_RESET;
			cfg_q.range_ms    <= RANGE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_OPTION_MODE: cfg_q.option_mode <= cfg_data[0];
				REG_MSGS_NEEDED: cfg_q.msgs_needed <= cfg_data[7:0];
				REG_RANGE_MS:    cfg_q.range_ms    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Requests are granted only while the queue can hold every one in flight.
	assign occupancy = TOT_W'(inflight) + TOT_W'(mid_count);
	assign full      = (occupancy >= TOT_W'(MID_DEPTH));
	assign in_take   = push & ~full;

	tcoe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_take),
		.in_item   (sample),
		.cfg       (cfg_q),
		.out_valid (front_valid),
		.out_item  (front_item),
		.inflight  (inflight)
	);

	tcoe_fifo #(
		.WIDTH ($bits(mid_item_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_valid),
		.wr_data (front_item),
		.rd_en   (mid_pop),
		.rd_data (mid_head),
		.empty   (mid_empty),
		.count   (mid_count)
	);

	assign res_space = (out_count < OUT_CNT_W'(OUT_DEPTH));

	tcoe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (~mid_empty),
		.item       (mid_head),
		.res_space  (res_space),
		.item_pop   (mid_pop),
		.res_valid  (res_valid),
		.res        (res)
	);

	// Results wait here until taken.
	assign out_pop = pop & ~empty;

	tcoe_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.rd_en   (out_pop),
		.rd_data (result),
		.empty   (empty),
		.count   (out_count)
	);

	// Requests in the front pipeline and the queue never exceed its depth.
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= TOT_W'(MID_DEPTH))
		else $error("more requests in flight than the queue can hold");

	// A result is only produced with room in the output queue.
	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_count < OUT_CNT_W'(OUT_DEPTH))
		else $error("result written into a full output queue");

	// The back part takes the queue head whenever there is room for its result.
	a_back_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!mid_empty && res_space |-> mid_pop && res_valid)
		else $error("back part idle with work and room available");

endmodule
`default_nettype wire

// ===== dv/tb_timestamp_clock_offset_estimator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timestamp_clock_offset_estimator - self-checking bench of the estimator
// Drives start and reply requests through the push port and pops results
// under random gaps on both sides. A short table covers the status codes,
// wrap-around and clamp cases and the register extremes. Four random phases
// follow: mostly well-formed measurements with random content, the rest noise.
// Every popped result is compared field by field with an in-bench estimator or a typed table result.
// ----------------------------------------------------------------------------
module tb_timestamp_clock_offset_estimator;
	import tcoe_pkg::*;

	localparam int    TIMEOUT_CYCLES = 300000;
	localparam int    HOLD_CYCLES    = 300;
	localparam int    MAX_REPORTS    = 10;
	localparam longint DAY_LEN       = longint'(DAY_MS);
	localparam longint HALF_LEN      = longint'(HALF_DAY);
	localparam longint CAP_LEN       = longint'(RTT_CAP);
	localparam longint UNSET         = longint'(NOT_SET);

	// One row of the directed table: a register write or a request.
	typedef struct {
		bit                   is_reg;
		logic [CFG_IDX_W-1:0] idx;
		logic [9:0]           val;
		sample_t              req;
		bit                   typed;
		logic [2:0]           typed_status;
	} step_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	sample_t               req_data = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	result_t               res_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Estimator copy: settings and measurement state.
	logic       set_option = 1'b0;
	logic [7:0] set_target = TARGET_RESET;
	logic [9:0] set_range  = RANGE_RESET;
	longint     est_rtt = longint'(RTT_RESET);
	longint     est_dev = 0;
	longint     est_min_fwd = UNSET;
	longint     est_min_bwd = UNSET;
	longint     est_least_sum = UNSET;
	longint     est_path_off = UNSET;
	longint     est_final_off = UNSET;
	logic [7:0] est_count = '0;
	bit         est_open = 1'b0;

	result_t   pending_results[$];
	step_row_t dir_rows[$];
	int        tx_idle_pct = 0;
	int        rx_idle_pct = 0;
	bit        hold_trigger = 1'b0;
	int        hold_left = 0;
	int        fail_count = 0;
	int        report_count = 0;
	int        items_sent = 0;
	int        cycle_count = 0;

	timestamp_clock_offset_estimator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (req_data),
		.empty     (empty),
		.pop       (pop),
		.result    (res_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Fold a delta into the half-open window of plus or minus twelve hours.
	function automatic longint fold_day(longint d);
		longint r;
		r = d % DAY_LEN;
		if (r < 0) r += DAY_LEN;
		if (r > HALF_LEN - 1) r -= DAY_LEN;
		return r;
	endfunction

	// Wrap any time into milliseconds of the day.
	function automatic logic [31:0] day_of(longint x);
		return 32'(((x % DAY_LEN) + DAY_LEN) % DAY_LEN);
	endfunction

	// Advance the estimator by one request and return the result it reports.
	function automatic result_t estimate_step(sample_t s);
		longint     snd, p1, p2, rcv, diff, dcl, dev, fwd, bwd;
		logic [2:0] st;
		result_t    r;
		snd = longint'(s.send_ms);
		p1  = longint'(s.peer1_ms);
		p2  = longint'(s.peer2_ms);
		rcv = longint'(s.recv_ms);
		st  = ST_ACCEPTED;
		if (!s.command) begin
			est_min_fwd   = UNSET;
			est_min_bwd   = UNSET;
			est_least_sum = UNSET;
			est_path_off  = UNSET;
			est_final_off = UNSET;
			est_count     = '0;
			est_open      = 1'b1;
		end else if (!est_open) begin
			st = ST_SKIPPED;
		end else if (set_option && (s.send_ms[31] || s.peer1_ms[31] ||
				s.peer2_ms[31] || s.recv_ms[31])) begin
			est_open = 1'b0;
			st = ST_NONSTD;
		end else if (set_option && (snd == 0 || p1 == 0 || p2 == 0 || rcv == 0)) begin
			est_open = 1'b0;
			st = ST_MISSING;
		end else if (rcv < snd) begin
			st = ST_SKIPPED;
		end else begin
			// Smoothed round trip and deviation, counted before the format check.
			diff = rcv - snd;
			dcl = (diff > CAP_LEN) ? CAP_LEN : diff;
			est_rtt = (est_rtt * 3 + dcl) / 4;
			dev = dcl - est_rtt;
			if (dev < 0) dev = -dev;
			est_dev = (est_dev * 3 + dev) / 4;
			if (est_count != COUNT_MAX) est_count++;
			if (!set_option && s.peer1_ms[31]) begin
				est_open = 1'b0;
				st = ST_NONSTD;
			end else begin
				fwd = fold_day(p1 - snd);
				bwd = fold_day(rcv - (set_option ? p2 : p1));
				if (fwd < est_min_fwd) est_min_fwd = fwd;
				if (bwd < est_min_bwd) est_min_bwd = bwd;
				if (fwd + bwd < est_least_sum) begin
					est_least_sum = fwd + bwd;
					est_path_off = (fwd - bwd) / 2;
				end
				if (diff < longint'(set_range)) begin
					est_min_fwd = fwd;
					est_min_bwd = bwd;
					st = ST_IN_RANGE;
				end
				if (est_count >= set_target) begin
					est_final_off = (est_min_fwd - est_min_bwd) / 2;
					est_open = 1'b0;
				end
			end
		end
		r.status         = st;
		r.done_res       = (est_final_off != UNSET);
		r.rtt_ms         = est_rtt[26:0];
		r.sigma_ms       = est_dev[26:0];
		r.min_rtt_ms     = est_least_sum[31:0];
		r.path_offset_ms = est_path_off[31:0];
		r.offset_ms      = est_final_off[31:0];
		r.accepted_count = est_count;
		return r;
	endfunction

	// Result of a request that leaves a never-touched measurement as it is.
	function automatic result_t quiet_result(logic [2:0] st);
		result_t r;
		r.status         = st;
		r.done_res       = 1'b0;
		r.rtt_ms         = RTT_RESET;
		r.sigma_ms       = '0;
		r.min_rtt_ms     = NOT_SET;
		r.path_offset_ms = NOT_SET;
		r.offset_ms      = NOT_SET;
		r.accepted_count = '0;
		return r;
	endfunction

	function automatic void add_request(logic cmd, logic [31:0] snd, logic [31:0] p1,
			logic [31:0] p2, logic [31:0] rcv, bit typed, logic [2:0] st);
		step_row_t row;
		row = '{default: '0};
		row.req = '{command: cmd, send_ms: snd, peer1_ms: p1, peer2_ms: p2, recv_ms: rcv};
		row.typed = typed;
		row.typed_status = st;
		dir_rows.push_back(row);
	endfunction

	function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [9:0] val);
		step_row_t row;
		row = '{default: '0};
		row.is_reg = 1'b1;
		row.idx = idx;
		row.val = val;
		dir_rows.push_back(row);
	endfunction

	// Offer one request at a falling edge; predict it once it is taken.
	task automatic send_request(input sample_t s, input bit typed, input result_t typed_res);
		result_t predicted;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		req_data <= s;
		do @(posedge clk); while (full);
		predicted = estimate_step(s);
		pending_results.push_back(typed ? typed_res : predicted);
		items_sent++;
		@(negedge clk);
	endtask

	// Stop sending and wait for every outstanding result.
	task automatic wait_drain();
		push <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	// One register write through the configuration channel.
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [9:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_OPTION_MODE: set_option = val[0];
			REG_MSGS_NEEDED: set_target = val[7:0];
			REG_RANGE_MS:    set_range = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Random request with every field drawn over its whole width.
	task automatic send_noise();
		sample_t s;
		s.command  = 1'($urandom_range(0, 1));
		s.send_ms  = $urandom();
		s.peer1_ms = $urandom();
		s.peer2_ms = $urandom();
		s.recv_ms  = $urandom();
		send_request(s, 1'b0, '0);
	endtask

	// A start followed by plausible replies, with an occasional broken field.
	task automatic send_measurement(input int replies);
		sample_t     s;
		longint      t, off, stride, rtt, peer_rx;
		logic [31:0] ts[4];
		int          g, k;
		t = $urandom_range(0, 86399999);
		if ($urandom_range(0, 99) < 70) off = longint'($urandom_range(0, 20000)) - 10000;
		else off = longint'($urandom_range(0, 86399999)) - HALF_LEN;
		stride = $urandom_range(1, 3000);
		s.command  = 1'b0;
		s.send_ms  = $urandom();
		s.peer1_ms = $urandom();
		s.peer2_ms = $urandom();
		s.recv_ms  = $urandom();
		send_request(s, 1'b0, '0);
		for (int i = 0; i < replies; i++) begin
			if ($urandom_range(0, 99) < 85) rtt = $urandom_range(0, 1200);
			else rtt = $urandom_range(0, 86399999);
			peer_rx = t + off + rtt / 2;
			ts[0] = day_of(t);
			ts[1] = day_of(peer_rx);
			ts[2] = day_of(peer_rx + $urandom_range(0, 3));
			ts[3] = day_of(t + rtt);
			g = $urandom_range(0, 99);
			k = $urandom_range(0, 3);
			if (g < 3) ts[k][31] = 1'b1;
			else if (g < 6) ts[k] = '0;
			else if (g < 9 && ts[0] > 500) ts[3] = ts[0] - $urandom_range(1, 500);
			s = '{command: 1'b1, send_ms: ts[0], peer1_ms: ts[1], peer2_ms: ts[2],
				recv_ms: ts[3]};
			send_request(s, 1'b0, '0);
			t += stride;
		end
	endtask

	// One random phase under a given setting and idling mix.
	task automatic run_phase(input logic opt, input logic [7:0] target,
			input logic [9:0] range_val, input int tx_pct, input int rx_pct,
			input int n_items, input bit with_hold);
		int goal;
		int len;
		bit paused;
		wait_drain();
		set_reg(REG_OPTION_MODE, {9'd0, opt});
		set_reg(REG_MSGS_NEEDED, {2'd0, target});
		set_reg(REG_RANGE_MS, range_val);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		if (with_hold) hold_trigger = 1'b1;
		goal = items_sent + n_items;
		paused = !with_hold;
		while (items_sent < goal) begin
			// In a hold phase, halfway through, let the block run dry once before going on.
			if (!paused && items_sent > goal - n_items / 2) begin
				wait_drain();
				paused = 1'b1;
			end
			if ($urandom_range(0, 99) < 80) begin
				if ($urandom_range(0, 99) < 30) len = $urandom_range(1, int'(target) + 3);
				else len = int'(target) + $urandom_range(0, 3);
				send_measurement(len);
			end else begin
				repeat ($urandom_range(1, 3)) send_noise();
			end
		end
	endtask

	// Receiver side: random pop gaps and one long hold-off on request.
	always @(negedge clk) begin
		if (hold_trigger) begin
			hold_trigger = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Compare each popped result with the oldest prediction.
	always @(posedge clk) begin
		result_t exp_res;
		bit      bad;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (report_count < MAX_REPORTS)
					$display("unexpected result: st=%0d cnt=%0d",
						res_data.status, res_data.accepted_count);
				report_count++;
			end else begin
				exp_res = pending_results.pop_front();
				bad = (res_data.status !== exp_res.status) ||
					(res_data.done_res !== exp_res.done_res) ||
					(res_data.rtt_ms !== exp_res.rtt_ms) ||
					(res_data.sigma_ms !== exp_res.sigma_ms) ||
					(res_data.min_rtt_ms !== exp_res.min_rtt_ms) ||
					(res_data.path_offset_ms !== exp_res.path_offset_ms) ||
					(res_data.offset_ms !== exp_res.offset_ms) ||
					(res_data.accepted_count !== exp_res.accepted_count);
				if (bad) begin
					fail_count++;
					if (report_count < MAX_REPORTS) begin
						$write("mismatch expected: st=%0d done=%0b rtt=%0d sig=%0d",
							exp_res.status, exp_res.done_res, exp_res.rtt_ms,
							exp_res.sigma_ms);
						$display(" min=%0d path=%0d off=%0d cnt=%0d",
							exp_res.min_rtt_ms, exp_res.path_offset_ms,
							exp_res.offset_ms, exp_res.accepted_count);
						$write("mismatch actual:   st=%0d done=%0b rtt=%0d sig=%0d",
							res_data.status, res_data.done_res, res_data.rtt_ms,
							res_data.sigma_ms);
						$display(" min=%0d path=%0d off=%0d cnt=%0d",
							res_data.min_rtt_ms, res_data.path_offset_ms,
							res_data.offset_ms, res_data.accepted_count);
					end
					report_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > TIMEOUT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Main sequence: reset, directed table, random phases, final check.
	initial begin
		// Default setting: plain mode, target 50, range 1.
		add_request(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, ST_SKIPPED);
		add_request(1'b0, '1, '1, '1, '1, 1'b1, ST_ACCEPTED);
		add_request(1'b1, '1, '1, '1, 32'd0, 1'b1, ST_SKIPPED);
		// Option mode: non-standard and missing timestamps end a measurement.
		add_reg(REG_OPTION_MODE, 10'd1);
		add_request(1'b1, 32'h8000_0000, 32'd1, 32'd1, 32'h8000_0001, 1'b1, ST_NONSTD);
		add_request(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, ST_ACCEPTED);
		add_request(1'b1, 32'd100, 32'd150, 32'd0, 32'd300, 1'b1, ST_MISSING);
		add_request(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, ST_ACCEPTED);
		add_request(1'b1, 32'd100, 32'd150, 32'd160, 32'h8000_0000, 1'b1, ST_NONSTD);
		add_request(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, ST_ACCEPTED);
		add_request(1'b1, 32'd1000, 32'd1500, 32'd1600, 32'd2000, 1'b0, ST_ACCEPTED);
		add_request(1'b1, 32'd5000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			1'b0, ST_ACCEPTED);
		add_request(1'b1, 32'd1, 32'd1, 32'd1, 32'd0, 1'b0, ST_ACCEPTED);
		// Plain mode: peer format flag, midnight wrap, half-day fold, done.
		add_reg(REG_OPTION_MODE, 10'd0);
		add_reg(REG_MSGS_NEEDED, 10'd2);
		add_reg(REG_RANGE_MS, 10'd1000);
		add_request(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, ST_ACCEPTED);
		add_request(1'b1, 32'd100, 32'h8000_0050, 32'd0, 32'd200, 1'b0, ST_ACCEPTED);
		add_request(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, ST_ACCEPTED);
		add_request(1'b1, 32'd86399000, 32'd500, 32'd600, 32'd86399800, 1'b0, ST_ACCEPTED);
		add_request(1'b1, 32'd1, 32'd43200001, 32'd0, 32'd2, 1'b0, ST_ACCEPTED);
		add_request(1'b1, 32'd10, 32'd20, 32'd30, 32'd40, 1'b0, ST_ACCEPTED);
		// Target of one and a zero range: first reply ends it, never in range.
		add_reg(REG_MSGS_NEEDED, 10'd1);
		add_reg(REG_RANGE_MS, 10'd0);
		add_request(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, ST_ACCEPTED);
		add_request(1'b1, 32'd0, 32'd0, 32'd0, '1, 1'b0, ST_ACCEPTED);
		add_request(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, ST_ACCEPTED);
		add_request(1'b1, 32'd5, 32'd5, 32'd5, 32'd5, 1'b0, ST_ACCEPTED);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_idle_pct = 29;
		rx_idle_pct = 49;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_reg) begin
				wait_drain();
				set_reg(dir_rows[i].idx, dir_rows[i].val);
			end else begin
				send_request(dir_rows[i].req, dir_rows[i].typed,
					quiet_result(dir_rows[i].typed_status));
			end
		end

		run_phase(1'b0, 8'd6, 10'd300, 29, 49, 300, 1'b0);
		run_phase(1'b1, 8'd10, 10'd1000, 49, 29, 300, 1'b0);
		run_phase(1'b0, 8'd255, 10'd0, 0, 0, 150, 1'b1);
		run_phase(1'b1, 8'd3, 10'd703, 0, 0, 270, 1'b0);

		wait_drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
